### sv/dma_interrupt_priority_registers_defines.svh
// assertion macros used by the checker file
`ifndef DMA_INTERRUPT_PRIORITY_REGISTERS_DEFINES_SVH
`define DMA_INTERRUPT_PRIORITY_REGISTERS_DEFINES_SVH

// property checked outside reset
`define DIP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dip assertion failed");

// property checked at every edge, reset included
`define DIP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("dip assertion failed");

`endif

### sv/dip_pkg.sv
// types and constants of the dma interrupt and priority register block
package dip_pkg;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  reg_select;
    logic [31:0] write_data;
    logic [3:0]  channel;
    logic [2:0]  field_kind;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  field_read;
    logic        irq_pending;
    logic        bad_channel;
  } out_item_t;

  typedef struct packed {
    logic [31:0] irq_lo;
    logic [31:0] irq_hi;
    logic [31:0] prio_lo;
    logic [31:0] prio_hi;
  } regs_t;

  localparam logic [2:0] OP_CPU_WRITE    = 3'd0;
  localparam logic [2:0] OP_READ         = 3'd1;
  localparam logic [2:0] OP_DIRECT_WRITE = 3'd2;
  localparam logic [2:0] OP_FIELD_WRITE  = 3'd3;
  localparam logic [2:0] OP_FIELD_READ   = 3'd4;
  localparam logic [2:0] OP_POLL         = 3'd5;

  localparam logic [1:0] SEL_IRQ_LO  = 2'd0;
  localparam logic [1:0] SEL_IRQ_HI  = 2'd1;
  localparam logic [1:0] SEL_PRIO_LO = 2'd2;
  localparam logic [1:0] SEL_PRIO_HI = 2'd3;

  localparam logic [2:0] FK_PRIORITY = 3'd0;
  localparam logic [2:0] FK_ENABLE   = 3'd1;
  localparam logic [2:0] FK_IRM      = 3'd2;
  localparam logic [2:0] FK_IQE      = 3'd3;
  localparam logic [2:0] FK_CMASK    = 3'd4;
  localparam logic [2:0] FK_CFLAG    = 3'd5;

  localparam logic [3:0] CH_PER_WORD  = 4'd7;
  localparam logic [3:0] NUM_CHANNELS = 4'd14;

  localparam logic [31:0] KEEP_TOP  = 32'hFF00_0000;
  localparam logic [31:0] LOW_BITS  = 32'h00FF_FFFF;
  localparam logic [31:0] FLAG_BITS = 32'h7F00_0000;
  localparam logic [31:0] MASK_BITS = 32'h007F_0000;

  localparam int unsigned ERR_BIT     = 15;
  localparam int unsigned MASTER_EN   = 23;
  localparam int unsigned MASTER_IRQ  = 31;
  localparam int unsigned MASK_LSB    = 16;
  localparam int unsigned FLAG_LSB    = 24;

endpackage

### sv/dip_exec.sv
// combinational access logic: next register words and result of one item
module dip_exec (
  input  dip_pkg::in_item_t  item,
  input  dip_pkg::regs_t     regs,
  output dip_pkg::regs_t     regs_nxt,
  output dip_pkg::out_item_t result
);
  import dip_pkg::*;

  logic        high;
  logic [2:0]  slot;
  logic        loc_ok;
  logic [1:0]  fsel;
  logic [4:0]  sh;
  logic [31:0] mk;
  logic [31:0] fword;
  logic [31:0] fword_new;
  logic [31:0] fval_word;
  logic [31:0] v;
  logic [31:0] cur;
  logic [6:0]  lo_hit;
  logic [6:0]  hi_hit;
  logic        pend;

  always_comb begin
    high = item.channel >= CH_PER_WORD;
    slot = high ? 3'(item.channel - CH_PER_WORD) : item.channel[2:0];
    loc_ok = item.channel < NUM_CHANNELS;
    mk = 32'd1;
    sh = 5'd0;
    fsel = SEL_IRQ_LO;
    case (item.field_kind)
      FK_PRIORITY: begin
        fsel = high ? SEL_PRIO_HI : SEL_PRIO_LO;
        sh = {slot, 2'b00};
        mk = 32'd7;
      end
      FK_ENABLE: begin
        fsel = high ? SEL_PRIO_HI : SEL_PRIO_LO;
        sh = {slot, 2'b11};
      end
      FK_IRM: begin
        fsel = SEL_IRQ_LO;
        sh = {2'b00, slot};
        if (high) loc_ok = 1'b0;
      end
      FK_IQE: begin
        fsel = SEL_IRQ_HI;
        sh = {1'b0, item.channel};
      end
      FK_CMASK: begin
        fsel = high ? SEL_IRQ_HI : SEL_IRQ_LO;
        sh = 5'(MASK_LSB) + {2'b00, slot};
      end
      FK_CFLAG: begin
        fsel = high ? SEL_IRQ_HI : SEL_IRQ_LO;
        sh = 5'(FLAG_LSB) + {2'b00, slot};
      end
      default: loc_ok = 1'b0;
    endcase

    case (fsel)
      SEL_IRQ_LO:  fword = regs.irq_lo;
      SEL_IRQ_HI:  fword = regs.irq_hi;
      SEL_PRIO_LO: fword = regs.prio_lo;
      default:     fword = regs.prio_hi;
    endcase

    v = (item.field_kind == FK_ENABLE) ? {31'd0, |item.write_data}
                                       : (item.write_data & mk);
    fword_new = (fword & ~(mk << sh)) | (v << sh);
    fval_word = (fword >> sh) & mk;

    case (item.reg_select)
      SEL_IRQ_LO:  cur = regs.irq_lo;
      SEL_IRQ_HI:  cur = regs.irq_hi;
      SEL_PRIO_LO: cur = regs.prio_lo;
      default:     cur = regs.prio_hi;
    endcase

    lo_hit = regs.irq_lo[MASK_LSB +: 7] & regs.irq_lo[FLAG_LSB +: 7];
    hi_hit = regs.irq_hi[MASK_LSB +: 7] & regs.irq_hi[FLAG_LSB +: 7];
    pend = ((|lo_hit || |hi_hit) && regs.irq_lo[MASTER_EN]) || regs.irq_lo[ERR_BIT];

    regs_nxt = regs;
    result = '0;

    case (item.opcode)
      OP_CPU_WRITE, OP_DIRECT_WRITE: begin
        if (item.opcode == OP_CPU_WRITE && !item.reg_select[1]) begin
          cur = ((cur & KEEP_TOP) | (item.write_data & LOW_BITS))
                & ~(item.write_data & FLAG_BITS);
        end else begin
          cur = item.write_data;
        end
        case (item.reg_select)
          SEL_IRQ_LO:  regs_nxt.irq_lo = cur;
          SEL_IRQ_HI:  regs_nxt.irq_hi = cur;
          SEL_PRIO_LO: regs_nxt.prio_lo = cur;
          default:     regs_nxt.prio_hi = cur;
        endcase
      end
      OP_FIELD_WRITE: begin
        if (loc_ok) begin
          case (fsel)
            SEL_IRQ_LO:  regs_nxt.irq_lo = fword_new;
            SEL_IRQ_HI:  regs_nxt.irq_hi = fword_new;
            SEL_PRIO_LO: regs_nxt.prio_lo = fword_new;
            default:     regs_nxt.prio_hi = fword_new;
          endcase
        end else begin
          result.bad_channel = 1'b1;
        end
      end
      OP_FIELD_READ: begin
        if (loc_ok) result.field_read = fval_word[2:0];
        else        result.bad_channel = 1'b1;
      end
      OP_POLL: begin
        if (pend) begin
          regs_nxt.irq_lo[MASTER_IRQ] = 1'b1;
          result.irq_pending = 1'b1;
        end
      end
      default: begin
      end
    endcase

    case (item.reg_select)
      SEL_IRQ_LO:  result.read_data = regs_nxt.irq_lo;
      SEL_IRQ_HI:  result.read_data = regs_nxt.irq_hi;
      SEL_PRIO_LO: result.read_data = regs_nxt.prio_lo;
      default:     result.read_data = regs_nxt.prio_hi;
    endcase
  end

endmodule

### sv/dma_interrupt_priority_registers.sv
// top level of the dma interrupt and priority register block
//
//   channel  ports                          direction
//   in       in_valid, in_ready, in_item    item into the block
//   out      out_valid, out_ready, out_item result item out of the block
//
// one item per cycle sustained while out_ready is high; out_valid rises once an accepted
// item has passed the input register, then the result register holding the updated words
// the register words change when an item moves from the input to the result register
// a stalled result holds the pipeline; in_ready stays high while the input register drains
// synchronous reset clears all four words and both valid flags
module dma_interrupt_priority_registers (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dip_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output dip_pkg::out_item_t  out_item
);
  import dip_pkg::*;

  logic       in_vld_r;
  in_item_t   in_item_r;
  logic       out_vld_r;
  out_item_t  out_item_r;
  regs_t      regs_r;
  regs_t      regs_nxt;
  out_item_t  result;
  logic       advance;

  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  dip_exec u_exec (
    .item     (in_item_r),
    .regs     (regs_r),
    .regs_nxt (regs_nxt),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      regs_r    <= '0;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (advance) begin
        out_vld_r <= 1'b1;
        regs_r    <= regs_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_item_r <= in_item;
    if (advance) out_item_r <= result;
  end

endmodule

### sv/dip_checker.sv
// port-level checker for the register block and its bind
`include "dma_interrupt_priority_registers_defines.svh"

module dip_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input dip_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input dip_pkg::out_item_t out_item
);
  import dip_pkg::*;

  `DIP_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_item))
  `DIP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item))
  `DIP_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid)
  `DIP_ASSERT(a_pend_not_bad, out_valid |-> !(out_item.irq_pending && out_item.bad_channel))
  `DIP_ASSERT(a_field_clean, out_valid && out_item.field_read != 3'd0 |-> !out_item.bad_channel && !out_item.irq_pending)

endmodule

bind dma_interrupt_priority_registers dip_checker u_dip_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

### tb/testbench.sv
// testbench for the dma interrupt and priority register block with a predicting scoreboard
module testbench;
  import dip_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 850;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam logic [2:0] FK_SPARE_6 = 3'd6;
  localparam logic [2:0] FK_SPARE_7 = 3'd7;
  localparam logic [3:0] CH_OUT_LOW = NUM_CHANNELS;
  localparam logic [3:0] CH_OUT_TOP = NUM_CHANNELS + 4'd1;

  class dip_shadow;
    logic [31:0] words [4];
    out_item_t   want_q[$];
    int          mismatches;
    int          accesses;
    int          pending_polls;
    int          bad_accesses;

    function new();
      for (int i = 0; i < 4; i++) words[i] = '0;
      mismatches = 0;
      accesses = 0;
      pending_polls = 0;
      bad_accesses = 0;
    endfunction

    function int outstanding();
      return want_q.size();
    endfunction

    // word index, bit position and width mask of a channel field
    function bit find_field(input logic [2:0] kind, input logic [3:0] ch,
                            output int idx, output int pos, output logic [31:0] fmask);
      bit hi_half;
      int slot;
      idx = SEL_IRQ_LO;
      pos = 0;
      fmask = 32'd1;
      if (ch >= NUM_CHANNELS) return 1'b0;
      hi_half = (ch >= CH_PER_WORD);
      slot = hi_half ? int'(ch) - int'(CH_PER_WORD) : int'(ch);
      case (kind)
        FK_PRIORITY: begin
          idx = hi_half ? SEL_PRIO_HI : SEL_PRIO_LO;
          pos = 4 * slot;
          fmask = 32'd7;
        end
        FK_ENABLE: begin
          idx = hi_half ? SEL_PRIO_HI : SEL_PRIO_LO;
          pos = 4 * slot + 3;
        end
        FK_IRM: begin
          if (hi_half) return 1'b0;
          idx = SEL_IRQ_LO;
          pos = slot;
        end
        FK_IQE: begin
          idx = SEL_IRQ_HI;
          pos = int'(ch);
        end
        FK_CMASK: begin
          idx = hi_half ? SEL_IRQ_HI : SEL_IRQ_LO;
          pos = MASK_LSB + slot;
        end
        FK_CFLAG: begin
          idx = hi_half ? SEL_IRQ_HI : SEL_IRQ_LO;
          pos = FLAG_LSB + slot;
        end
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function out_item_t apply_access(in_item_t it);
      out_item_t   r;
      int          sel;
      int          idx;
      int          pos;
      logic [31:0] fmask;
      logic [31:0] v;
      logic [31:0] d;
      logic        me;
      logic        err;
      logic [6:0]  lo_hit;
      logic [6:0]  hi_hit;
      r = '0;
      sel = int'(it.reg_select);
      d = it.write_data;
      case (it.opcode)
        OP_CPU_WRITE: begin
          if (it.reg_select == SEL_IRQ_LO || it.reg_select == SEL_IRQ_HI)
            words[sel] = ((words[sel] & KEEP_TOP) | (d & LOW_BITS)) & ~(d & FLAG_BITS);
          else
            words[sel] = d;
        end
        OP_DIRECT_WRITE: words[sel] = d;
        OP_FIELD_WRITE: begin
          if (find_field(it.field_kind, it.channel, idx, pos, fmask)) begin
            v = (it.field_kind == FK_ENABLE) ? {31'd0, d != 32'd0} : (d & fmask);
            words[idx] = (words[idx] & ~(fmask << pos)) | (v << pos);
          end else begin
            r.bad_channel = 1'b1;
          end
        end
        OP_FIELD_READ: begin
          if (find_field(it.field_kind, it.channel, idx, pos, fmask)) begin
            v = (words[idx] >> pos) & fmask;
            r.field_read = v[2:0];
          end else begin
            r.bad_channel = 1'b1;
          end
        end
        OP_POLL: begin
          me = words[SEL_IRQ_LO][MASTER_EN];
          err = words[SEL_IRQ_LO][ERR_BIT];
          lo_hit = words[SEL_IRQ_LO][22:16] & words[SEL_IRQ_LO][30:24];
          hi_hit = words[SEL_IRQ_HI][22:16] & words[SEL_IRQ_HI][30:24];
          if ((lo_hit != 0 && me) || err || (hi_hit != 0 && me)) begin
            words[SEL_IRQ_LO][MASTER_IRQ] = 1'b1;
            r.irq_pending = 1'b1;
          end
        end
        default: ;
      endcase
      r.read_data = words[sel];
      return r;
    endfunction

    function void note_access(in_item_t it);
      out_item_t r;
      r = apply_access(it);
      accesses++;
      if (r.irq_pending) pending_polls++;
      if (r.bad_channel) bad_accesses++;
      want_q.push_back(r);
    endfunction

    function void check_response(out_item_t got);
      out_item_t want;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: read_data=%h field_read=%0d pending=%0b bad=%0b",
                   got.read_data, got.field_read, got.irq_pending, got.bad_channel);
        return;
      end
      want = want_q.pop_front();
      if (got.read_data !== want.read_data || got.field_read !== want.field_read ||
          got.irq_pending !== want.irq_pending || got.bad_channel !== want.bad_channel) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: read_data %h/%h field_read %0d/%0d pending %0b/%0b bad %0b/%0b",
                   $time, want.read_data, got.read_data, want.field_read, got.field_read,
                   want.irq_pending, got.irq_pending, want.bad_channel, got.bad_channel);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  dip_shadow shadow;
  bit        send_calm;
  bit        recv_calm;
  int        idle_cycles = 0;

  dma_interrupt_priority_registers dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function in_item_t acc(logic [2:0] op, logic [1:0] sel, logic [31:0] data,
                         logic [3:0] ch, logic [2:0] kind);
    in_item_t it;
    it.opcode = op;
    it.reg_select = sel;
    it.write_data = data;
    it.channel = ch;
    it.field_kind = kind;
    return it;
  endfunction

  function in_item_t random_access();
    int          r;
    logic [2:0]  op;
    logic [31:0] data;
    logic [3:0]  ch;
    logic [2:0]  kind;
    r = $urandom_range(0, 99);
    if (r < 22) op = OP_FIELD_WRITE;
    else if (r < 40) op = OP_FIELD_READ;
    else if (r < 52) op = OP_CPU_WRITE;
    else if (r < 62) op = OP_DIRECT_WRITE;
    else if (r < 72) op = OP_READ;
    else if (r < 94) op = OP_POLL;
    else if (r < 97) op = OP_SPARE_6;
    else op = OP_SPARE_7;
    r = $urandom_range(0, 9);
    if (r == 0) data = 32'd0;
    else if (r == 1) data = 32'hFFFF_FFFF;
    else if (r == 2) data = $urandom_range(0, 7);
    else data = $urandom();
    ch = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(14, 15)) : 4'($urandom_range(0, 13));
    kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    return acc(op, 2'($urandom_range(0, 3)), data, ch, kind);
  endfunction

  task automatic send(in_item_t it);
    int gap;
    gap = send_calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.outstanding() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) shadow.note_access(in_item);
    if (rst_n && out_valid && out_ready) shadow.check_response(out_item);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side backpressure
  initial begin
    int stall;
    int cyc;
    stall = 0;
    cyc = 0;
    recv_calm = 1'b0;
    out_ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 128 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!recv_calm) stall = idle_len();
      end
    end
  end

  initial begin
    shadow = new();
    send_calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed accesses
    send(acc(OP_READ, SEL_IRQ_LO, 32'd0, 4'd0, FK_PRIORITY));
    send(acc(OP_DIRECT_WRITE, SEL_IRQ_LO, 32'hFFFF_FFFF, 4'd0, FK_PRIORITY));
    send(acc(OP_CPU_WRITE, SEL_IRQ_LO, 32'h0000_0000, 4'd0, FK_PRIORITY));
    send(acc(OP_CPU_WRITE, SEL_IRQ_LO, 32'h7F00_0000, 4'd0, FK_PRIORITY));
    send(acc(OP_POLL, SEL_IRQ_LO, 32'd0, 4'd0, FK_PRIORITY));
    send(acc(OP_DIRECT_WRITE, SEL_IRQ_LO, 32'h0000_8000, 4'd0, FK_PRIORITY));
    send(acc(OP_POLL, SEL_IRQ_LO, 32'd0, 4'd0, FK_PRIORITY));
    send(acc(OP_DIRECT_WRITE, SEL_IRQ_LO, 32'h0080_0000, 4'd0, FK_PRIORITY));
    send(acc(OP_DIRECT_WRITE, SEL_IRQ_HI, 32'h0101_0000, 4'd0, FK_PRIORITY));
    send(acc(OP_POLL, SEL_IRQ_HI, 32'd0, 4'd0, FK_PRIORITY));
    send(acc(OP_CPU_WRITE, SEL_IRQ_HI, 32'hFFFF_FFFF, 4'd0, FK_PRIORITY));
    send(acc(OP_CPU_WRITE, SEL_PRIO_LO, 32'hFFFF_FFFF, 4'd0, FK_PRIORITY));
    send(acc(OP_CPU_WRITE, SEL_PRIO_HI, 32'h0000_0000, 4'd0, FK_PRIORITY));
    send(acc(OP_FIELD_WRITE, SEL_PRIO_HI, 32'hFFFF_FFFF, 4'd13, FK_PRIORITY));
    send(acc(OP_FIELD_READ, SEL_PRIO_HI, 32'd0, 4'd13, FK_PRIORITY));
    send(acc(OP_FIELD_WRITE, SEL_PRIO_LO, 32'd2, 4'd0, FK_ENABLE));
    send(acc(OP_FIELD_READ, SEL_PRIO_LO, 32'd0, 4'd0, FK_ENABLE));
    send(acc(OP_FIELD_WRITE, SEL_IRQ_LO, 32'd1, 4'd7, FK_IRM));
    send(acc(OP_FIELD_WRITE, SEL_IRQ_LO, 32'd1, 4'd6, FK_IRM));
    send(acc(OP_FIELD_READ, SEL_IRQ_LO, 32'd0, 4'd6, FK_IRM));
    send(acc(OP_FIELD_WRITE, SEL_IRQ_HI, 32'd1, 4'd13, FK_IQE));
    send(acc(OP_FIELD_WRITE, SEL_IRQ_HI, 32'd1, 4'd7, FK_CMASK));
    send(acc(OP_FIELD_WRITE, SEL_IRQ_LO, 32'd1, 4'd0, FK_CFLAG));
    send(acc(OP_FIELD_READ, SEL_IRQ_LO, 32'd0, CH_OUT_TOP, FK_CFLAG));
    send(acc(OP_FIELD_READ, SEL_IRQ_HI, 32'd0, CH_OUT_LOW, FK_SPARE_7));
    send(acc(OP_FIELD_WRITE, SEL_PRIO_LO, 32'd5, 4'd3, FK_SPARE_6));
    send(acc(OP_SPARE_6, SEL_IRQ_LO, 32'hFFFF_FFFF, 4'd0, FK_PRIORITY));
    send(acc(OP_SPARE_7, SEL_PRIO_HI, 32'hFFFF_FFFF, 4'd0, FK_PRIORITY));

    // random accesses
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) send_calm = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) drain();
      send(random_access());
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d accesses, %0d polls with an interrupt pending, %0d rejected field accesses",
             shadow.accesses, shadow.pending_polls, shadow.bad_accesses);
    $display("%0d result items disagreed with the prediction", shadow.mismatches);
    if (shadow.mismatches == 0 && shadow.outstanding() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
